FILE: hw/rtl/i2cpm_pkg.sv
// Shared types and constants of the power monitor bus register block.
// No dependencies; used by every module of the block.
`default_nettype none

package i2cpm_pkg;

  localparam logic [15:0] CONFIG_RESET_DEFAULT = 16'd14751;

  // Configuration port register indexes
  localparam logic [2:0] CFG_DEVICE_ADDRESS = 3'd0;
  localparam logic [2:0] CFG_BUS_VOLTAGE    = 3'd1;
  localparam logic [2:0] CFG_SHUNT_VOLTAGE  = 3'd2;
  localparam logic [2:0] CFG_CURRENT        = 3'd3;
  localparam logic [2:0] CFG_POWER          = 3'd4;

  // Bus-visible register map
  localparam logic [7:0] REG_CONFIG      = 8'd0;
  localparam logic [7:0] REG_SHUNT       = 8'd1;
  localparam logic [7:0] REG_BUS         = 8'd2;
  localparam logic [7:0] REG_POWER       = 8'd3;
  localparam logic [7:0] REG_CURRENT     = 8'd4;
  localparam logic [7:0] REG_CALIBRATION = 8'd5;

  localparam logic [7:0] POINTER_MASK = 8'h07;

  // Reply kinds
  localparam logic REPLY_ACK  = 1'b0;
  localparam logic REPLY_READ = 1'b1;

  localparam logic [7:0] ACK_DATA = 8'd1;

  localparam int MAX_REPLIES = 3;

  typedef struct packed {
    logic       is_start;
    logic       is_stop;
    logic       is_write;
    logic       is_read;
    logic [7:0] address_byte;
    logic [7:0] data_byte;
  } msg_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [15:0] bus_voltage_code;
    logic [15:0] shunt_voltage_code;
    logic [15:0] current_code;
    logic [15:0] power_code;
  } cfg_regs_t;

  typedef struct packed {
    logic        selected;
    logic [7:0]  selected_address;
    logic        pointer_valid;
    logic [7:0]  register_pointer;
    logic        read_byte_phase;
    logic        write_byte_phase;
    logic [7:0]  pending_msb;
    logic [15:0] config_word;
    logic [15:0] calibration_word;
  } mon_state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] address;
    logic [7:0] data;
    logic       last;
  } reply_t;

endpackage

`default_nettype wire

FILE: hw/rtl/i2c_power_monitor_registers.sv
// Top level of the power monitor bus register block: state and settings registers.
// Depends on i2cpm_pkg, i2cpm_msg_logic and i2cpm_reply_buf.
//
// Usage
//   Input channel (in_valid / in_ready) carries one bus message per request:
//   start, stop, write and read flags with the address byte and data byte.
//   Output channel (out_valid / out_ready) carries replies: acknowledge or
//   read data byte, the latched address byte, and last on a message's final
//   reply. A message gives zero to three replies; one that gives none still
//   updates state (stop, a start for another address, data while deselected).
//   Settings port: cfg_write with cfg_index and cfg_data writes device address,
//   bus voltage, shunt voltage, current and power codes; indexes past the
//   list are ignored. Write settings only while no replies are outstanding.
// Ordering and throughput
//   A taken request loads its replies into the reply register, and state is
//   updated in the same cycle, so requests can follow back to back. The reply
//   register sets the rate: several replies hold the input until they drain,
//   so one-reply requests flow one a cycle while the receiver is ready.
// Reset and stall
//   rst (synchronous) empties the reply register, deselects the device, clears
//   the pointer and byte phases and restores settings to their defaults.
//   While the receiver stalls, the reply register holds and in_ready drops
//   once the last queued reply cannot leave this cycle.
`default_nettype none

module i2c_power_monitor_registers #(
  parameter logic [15:0] CONFIG_RESET_VALUE = i2cpm_pkg::CONFIG_RESET_DEFAULT
) (
  input  wire        clk,
  input  wire        rst,
  // settings write port
  input  wire        cfg_write,
  input  wire [2:0]  cfg_index,
  input  wire [15:0] cfg_data,
  // message channel
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        is_start,
  input  wire        is_stop,
  input  wire        is_write,
  input  wire        is_read,
  input  wire [7:0]  address_byte,
  input  wire [7:0]  data_byte,
  // reply channel
  output logic       out_valid,
  input  wire        out_ready,
  output logic       reply_kind,
  output logic [7:0] reply_address,
  output logic [7:0] reply_data,
  output logic       last
);

  i2cpm_pkg::cfg_regs_t  cfg;
  i2cpm_pkg::mon_state_t state;
  i2cpm_pkg::mon_state_t state_next;
  i2cpm_pkg::msg_t       msg;
  i2cpm_pkg::reply_t     replies [i2cpm_pkg::MAX_REPLIES];
  i2cpm_pkg::reply_t     head;
  logic [1:0]            reply_count;
  logic                  accept;

  assign msg = '{is_start: is_start, is_stop: is_stop, is_write: is_write,
                 is_read: is_read, address_byte: address_byte,
                 data_byte: data_byte};

  assign accept = in_valid && in_ready;

  // Settings registers: plain indexed writes, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address     <= 7'd64;
      cfg.bus_voltage_code   <= 16'd10000;
      cfg.shunt_voltage_code <= 16'd10000;
      cfg.current_code       <= 16'd100;
      cfg.power_code         <= 16'd25;
    end else if (cfg_write) begin
      case (cfg_index)
        i2cpm_pkg::CFG_DEVICE_ADDRESS: cfg.device_address     <= cfg_data[6:0];
        i2cpm_pkg::CFG_BUS_VOLTAGE:    cfg.bus_voltage_code   <= cfg_data;
        i2cpm_pkg::CFG_SHUNT_VOLTAGE:  cfg.shunt_voltage_code <= cfg_data;
        i2cpm_pkg::CFG_CURRENT:        cfg.current_code       <= cfg_data;
        i2cpm_pkg::CFG_POWER:          cfg.power_code         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Slave state: advance once per taken request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{selected: 1'b0, selected_address: '0, pointer_valid: 1'b0,
                 register_pointer: '0, read_byte_phase: 1'b0,
                 write_byte_phase: 1'b0, pending_msb: '0,
                 config_word: CONFIG_RESET_VALUE, calibration_word: '0};
    end else if (accept) begin
      state <= state_next;
    end
  end

  i2cpm_msg_logic #(
    .CONFIG_RESET_VALUE(CONFIG_RESET_VALUE)
  ) u_msg_logic (
    .msg        (msg),
    .cfg        (cfg),
    .cur        (state),
    .state_next (state_next),
    .replies    (replies),
    .reply_count(reply_count)
  );

  i2cpm_reply_buf u_reply_buf (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .load_replies(replies),
    .load_count  (reply_count),
    .can_load    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .head        (head)
  );

  assign reply_kind    = head.kind;
  assign reply_address = head.address;
  assign reply_data    = head.data;
  assign last          = head.last;

endmodule

`default_nettype wire

FILE: hw/rtl/i2cpm_msg_logic.sv
// Per-message update of the slave state and build of its replies.
// Depends on i2cpm_pkg.
`default_nettype none

module i2cpm_msg_logic #(
  parameter logic [15:0] CONFIG_RESET_VALUE = i2cpm_pkg::CONFIG_RESET_DEFAULT
) (
  input  wire i2cpm_pkg::msg_t       msg,
  input  wire i2cpm_pkg::cfg_regs_t  cfg,
  input  wire i2cpm_pkg::mon_state_t cur,
  output i2cpm_pkg::mon_state_t      state_next,
  output i2cpm_pkg::reply_t          replies [i2cpm_pkg::MAX_REPLIES],
  output logic [1:0]                 reply_count
);

  i2cpm_pkg::mon_state_t s;
  i2cpm_pkg::reply_t     r [i2cpm_pkg::MAX_REPLIES];
  logic [1:0]            n;
  logic [15:0]           word_in;
  logic [15:0]           word_out;

  always_comb begin
    s        = cur;
    n        = 2'd0;
    word_in  = {cur.pending_msb, msg.data_byte};
    word_out = '0;
    for (int i = 0; i < i2cpm_pkg::MAX_REPLIES; i++) begin
      r[i] = '0;
    end

    // stop ends the transaction; a half-written word is dropped
    if (msg.is_stop) begin
      s.selected         = 1'b0;
      s.selected_address = '0;
      s.pointer_valid    = 1'b0;
      s.read_byte_phase  = 1'b0;
      s.write_byte_phase = 1'b0;
    end

    if (msg.is_start) begin
      s.selected         = 1'b0;
      s.selected_address = '0;
      if (msg.address_byte[7:1] == cfg.device_address) begin
        s.selected         = 1'b1;
        s.selected_address = msg.address_byte;
        s.read_byte_phase  = 1'b0;
        s.write_byte_phase = 1'b0;
        r[n] = '{kind: i2cpm_pkg::REPLY_ACK, address: msg.address_byte,
                 data: i2cpm_pkg::ACK_DATA, last: 1'b0};
        n = n + 2'd1;
      end
    end

    if (s.selected && msg.is_write) begin
      r[n] = '{kind: i2cpm_pkg::REPLY_ACK, address: s.selected_address,
               data: i2cpm_pkg::ACK_DATA, last: 1'b0};
      n = n + 2'd1;
      if (!s.pointer_valid) begin
        s.register_pointer = msg.data_byte & i2cpm_pkg::POINTER_MASK;
        s.pointer_valid    = 1'b1;
        s.read_byte_phase  = 1'b0;
        s.write_byte_phase = 1'b0;
      end else if (!s.write_byte_phase) begin
        s.pending_msb      = msg.data_byte;
        s.write_byte_phase = 1'b1;
      end else begin
        // commit the word; config bit 15 restores the default
        if (s.register_pointer == i2cpm_pkg::REG_CONFIG) begin
          s.config_word = word_in[15] ? CONFIG_RESET_VALUE : word_in;
        end else if (s.register_pointer == i2cpm_pkg::REG_CALIBRATION) begin
          s.calibration_word = word_in;
        end
        s.write_byte_phase = 1'b0;
        s.register_pointer = s.register_pointer + 8'd1;
      end
    end

    if (s.selected && msg.is_read) begin
      if (!s.pointer_valid) begin
        s.register_pointer = i2cpm_pkg::REG_CONFIG;
        s.pointer_valid    = 1'b1;
        s.read_byte_phase  = 1'b0;
      end
      case (s.register_pointer)
        i2cpm_pkg::REG_CONFIG:      word_out = s.config_word;
        i2cpm_pkg::REG_SHUNT:       word_out = cfg.shunt_voltage_code;
        i2cpm_pkg::REG_BUS:         word_out = cfg.bus_voltage_code;
        i2cpm_pkg::REG_POWER:       word_out = cfg.power_code;
        i2cpm_pkg::REG_CURRENT:     word_out = cfg.current_code;
        i2cpm_pkg::REG_CALIBRATION: word_out = s.calibration_word;
        default:                    word_out = '0;
      endcase
      r[n] = '{kind: i2cpm_pkg::REPLY_READ, address: s.selected_address,
               data: s.read_byte_phase ? word_out[7:0] : word_out[15:8],
               last: 1'b0};
      n = n + 2'd1;
      if (s.read_byte_phase) begin
        s.read_byte_phase  = 1'b0;
        s.register_pointer = s.register_pointer + 8'd1;
      end else begin
        s.read_byte_phase = 1'b1;
      end
    end

    if (n != 2'd0) begin
      r[n - 2'd1].last = 1'b1;
    end
  end

  assign state_next  = s;
  assign replies     = r;
  assign reply_count = n;

endmodule

`default_nettype wire

FILE: hw/rtl/i2cpm_reply_buf.sv
// Output register for the up to three replies of one message, drained in order.
// Depends on i2cpm_pkg.
`default_nettype none

module i2cpm_reply_buf (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       load,
  input  wire i2cpm_pkg::reply_t    load_replies [i2cpm_pkg::MAX_REPLIES],
  input  wire [1:0]                 load_count,
  output logic                      can_load,
  output logic                      out_valid,
  input  wire                       out_ready,
  output i2cpm_pkg::reply_t         head
);

  i2cpm_pkg::reply_t slots [i2cpm_pkg::MAX_REPLIES];
  logic [1:0]        count;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign can_load  = (count == 2'd0) || (count == 2'd1 && out_ready);
  assign head      = slots[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= load_count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  // payload: load a fresh set, or advance on each taken reply
  always_ff @(posedge clk) begin
    if (load) begin
      slots <= load_replies;
    end else if (pop) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/i2cpm_checker.sv
// Port-level checks of the power monitor bus register block, bound to its top.
// Depends on i2cpm_pkg and i2c_power_monitor_registers.
`default_nettype none

module i2cpm_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire       reply_kind,
  input wire [7:0] reply_address,
  input wire [7:0] reply_data,
  input wire       last
);

  // a stalled reply stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("reply dropped while stalled");

  // hold the whole reply steady while the receiver stalls
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({reply_kind, reply_address, reply_data, last}))
    else $error("reply changed while stalled");

  // acknowledges always carry data one
  a_ack_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_kind == i2cpm_pkg::REPLY_ACK |-> reply_data == i2cpm_pkg::ACK_DATA)
    else $error("acknowledge with wrong data");

  // with nothing queued the block must take a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty reply register");

  // reset empties the reply register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("reply offered after reset");

endmodule

bind i2c_power_monitor_registers i2cpm_checker u_i2cpm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .reply_kind   (reply_kind),
  .reply_address(reply_address),
  .reply_data   (reply_data),
  .last         (last)
);

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the power monitor bus register block.
// Depends on i2cpm_pkg and i2c_power_monitor_registers.
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  // Address bytes of the reset device address (64) in both directions, and a write to another device
  localparam logic [7:0] HOME_WR  = 8'h80;
  localparam logic [7:0] HOME_RD  = 8'h81;
  localparam logic [7:0] OTHER_WR = 8'h20;

  // Tracks the bus-side register state and the replies still owed by the block.
  class pm_reply_checker;
    bit [6:0]  dev_addr;
    bit [15:0] bus_code;
    bit [15:0] shunt_code;
    bit [15:0] current_code;
    bit [15:0] power_code;

    bit        sel;
    bit [7:0]  sel_addr;
    bit        ptr_ok;
    bit [7:0]  ptr;
    bit        rd_lsb;
    bit        wr_lsb;
    bit [7:0]  held_msb;
    bit [15:0] cfg_word;
    bit [15:0] cal_word;

    i2cpm_pkg::reply_t replies_due[$];
    int                errors;

    function new();
      dev_addr     = 7'd64;
      bus_code     = 16'd10000;
      shunt_code   = 16'd10000;
      current_code = 16'd100;
      power_code   = 16'd25;
      sel      = 1'b0;
      sel_addr = '0;
      ptr_ok   = 1'b0;
      ptr      = '0;
      rd_lsb   = 1'b0;
      wr_lsb   = 1'b0;
      held_msb = '0;
      cfg_word = i2cpm_pkg::CONFIG_RESET_DEFAULT;
      cal_word = '0;
      errors   = 0;
    endfunction

    function void set_register(bit [2:0] idx, bit [15:0] v);
      case (idx)
        i2cpm_pkg::CFG_DEVICE_ADDRESS: dev_addr     = v[6:0];
        i2cpm_pkg::CFG_BUS_VOLTAGE:    bus_code     = v;
        i2cpm_pkg::CFG_SHUNT_VOLTAGE:  shunt_code   = v;
        i2cpm_pkg::CFG_CURRENT:        current_code = v;
        i2cpm_pkg::CFG_POWER:          power_code   = v;
        default: ;
      endcase
    endfunction

    function bit [15:0] word_at_pointer();
      case (ptr)
        i2cpm_pkg::REG_CONFIG:      return cfg_word;
        i2cpm_pkg::REG_SHUNT:       return shunt_code;
        i2cpm_pkg::REG_BUS:         return bus_code;
        i2cpm_pkg::REG_POWER:       return power_code;
        i2cpm_pkg::REG_CURRENT:     return current_code;
        i2cpm_pkg::REG_CALIBRATION: return cal_word;
        default:                    return '0;
      endcase
    endfunction

    function i2cpm_pkg::reply_t make_reply(bit k, bit [7:0] d);
      i2cpm_pkg::reply_t r;
      r.kind    = k;
      r.address = sel_addr;
      r.data    = d;
      r.last    = 1'b0;
      return r;
    endfunction

    // Work out the replies of one accepted request: stop, start, write, read in turn.
    function void take_message(i2cpm_pkg::msg_t m);
      i2cpm_pkg::reply_t batch[$];
      bit [15:0]         w;
      if (m.is_stop) begin
        sel      = 1'b0;
        sel_addr = '0;
        ptr_ok   = 1'b0;
        rd_lsb   = 1'b0;
        wr_lsb   = 1'b0;
      end
      if (m.is_start) begin
        sel      = 1'b0;
        sel_addr = '0;
        if (m.address_byte[7:1] == dev_addr) begin
          sel      = 1'b1;
          sel_addr = m.address_byte;
          rd_lsb   = 1'b0;
          wr_lsb   = 1'b0;
          batch.push_back(make_reply(i2cpm_pkg::REPLY_ACK, i2cpm_pkg::ACK_DATA));
        end
      end
      if (sel && m.is_write) begin
        batch.push_back(make_reply(i2cpm_pkg::REPLY_ACK, i2cpm_pkg::ACK_DATA));
        if (!ptr_ok) begin
          ptr    = m.data_byte & i2cpm_pkg::POINTER_MASK;
          ptr_ok = 1'b1;
          rd_lsb = 1'b0;
          wr_lsb = 1'b0;
        end else if (!wr_lsb) begin
          held_msb = m.data_byte;
          wr_lsb   = 1'b1;
        end else begin
          w = {held_msb, m.data_byte};
          if (ptr == i2cpm_pkg::REG_CONFIG)
            cfg_word = w[15] ? i2cpm_pkg::CONFIG_RESET_DEFAULT : w;
          else if (ptr == i2cpm_pkg::REG_CALIBRATION)
            cal_word = w;
          wr_lsb = 1'b0;
          ptr    = ptr + 8'd1;
        end
      end
      if (sel && m.is_read) begin
        if (!ptr_ok) begin
          ptr    = i2cpm_pkg::REG_CONFIG;
          ptr_ok = 1'b1;
          rd_lsb = 1'b0;
        end
        w = word_at_pointer();
        if (!rd_lsb) begin
          batch.push_back(make_reply(i2cpm_pkg::REPLY_READ, w[15:8]));
          rd_lsb = 1'b1;
        end else begin
          batch.push_back(make_reply(i2cpm_pkg::REPLY_READ, w[7:0]));
          rd_lsb = 1'b0;
          ptr    = ptr + 8'd1;
        end
      end
      if (batch.size() > 0)
        batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i])
        replies_due.push_back(batch[i]);
    endfunction

    function void check_reply(i2cpm_pkg::reply_t r);
      i2cpm_pkg::reply_t want;
      if (replies_due.size() == 0) begin
        $error("unexpected reply: reply_kind %0d reply_address %0h reply_data %0h last %0d",
               r.kind, r.address, r.data, r.last);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (r.kind !== want.kind) begin
        $error("reply_kind: expected %0d, actual %0d", want.kind, r.kind);
        errors++;
      end
      if (r.address !== want.address) begin
        $error("reply_address: expected %0h, actual %0h", want.address, r.address);
        errors++;
      end
      if (r.data !== want.data) begin
        $error("reply_data: expected %0h, actual %0h", want.data, r.data);
        errors++;
      end
      if (r.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, r.last);
        errors++;
      end
    endfunction

    function int outstanding();
      return replies_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        is_start;
  logic        is_stop;
  logic        is_write;
  logic        is_read;
  logic [7:0]  address_byte;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic        reply_kind;
  logic [7:0]  reply_address;
  logic [7:0]  reply_data;
  logic        last;

  pm_reply_checker   sb;
  i2cpm_pkg::reply_t seen_reply;
  bit                gaps_on;
  int                rx_hold;
  int                cycle_count;

  i2c_power_monitor_registers u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .is_start     (is_start),
    .is_stop      (is_stop),
    .is_write     (is_write),
    .is_read      (is_read),
    .address_byte (address_byte),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reply_kind   (reply_kind),
    .reply_address(reply_address),
    .reply_data   (reply_data),
    .last         (last)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Idle length for either side: mostly none or short, now and then long.
  // With gaps switched off both sides run flat out.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 30);
  endfunction

  function automatic i2cpm_pkg::msg_t bus_msg(bit st, bit sp, bit wr, bit rd, bit [7:0] a,
                                              bit [7:0] d);
    i2cpm_pkg::msg_t m;
    m.is_start     = st;
    m.is_stop      = sp;
    m.is_write     = wr;
    m.is_read      = rd;
    m.address_byte = a;
    m.data_byte    = d;
    return m;
  endfunction

  // Reply side: check each accepted reply, then decide whether to stall next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_reply.kind    = reply_kind;
      seen_reply.address = reply_address;
      seen_reply.data    = reply_data;
      seen_reply.last    = last;
      sb.check_reply(seen_reply);
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      rx_hold = pick_gap();
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: give up well past the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one request after a random gap and hold it until taken. Valid is only
  // dropped when a gap follows, so back-to-back requests keep it high throughout.
  task automatic send_request(i2cpm_pkg::msg_t m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    is_start     <= m.is_start;
    is_stop      <= m.is_stop;
    is_write     <= m.is_write;
    is_read      <= m.is_read;
    address_byte <= m.address_byte;
    data_byte    <= m.data_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_message(m);
  endtask

  // Drop valid and let every owed reply drain, then allow for requests that
  // give no reply but may still be in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setting(bit [2:0] idx, bit [15:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_register(idx, v);
  endtask

  // Load one set of settings; the first three phases pin the extremes.
  task automatic apply_settings(int phase);
    bit [15:0] dev_v, bus_v, shunt_v, cur_v, pwr_v;
    bit [2:0]  spare_idx;
    int        step;
    dev_v   = 16'($urandom);
    bus_v   = 16'($urandom);
    shunt_v = 16'($urandom);
    cur_v   = 16'($urandom);
    pwr_v   = 16'($urandom);
    case (phase)
      0: begin
        // address 0 (upper bits set, must be masked off) and all codes zero
        dev_v   = 16'hFF80;
        bus_v   = '0;
        shunt_v = '0;
        cur_v   = '0;
        pwr_v   = '0;
      end
      1: begin
        dev_v   = 16'hFFFF;
        bus_v   = 16'hFFFF;
        shunt_v = 16'hFFFF;
        cur_v   = 16'hFFFF;
        pwr_v   = 16'hFFFF;
      end
      2: begin
        // most negative shunt, most positive current
        shunt_v = 16'h8000;
        cur_v   = 16'h7FFF;
      end
      default: ;
    endcase
    step      = $urandom_range(1, 3);
    spare_idx = i2cpm_pkg::CFG_POWER + step[2:0];
    write_setting(i2cpm_pkg::CFG_DEVICE_ADDRESS, dev_v);
    write_setting(i2cpm_pkg::CFG_BUS_VOLTAGE, bus_v);
    write_setting(i2cpm_pkg::CFG_SHUNT_VOLTAGE, shunt_v);
    write_setting(i2cpm_pkg::CFG_CURRENT, cur_v);
    write_setting(i2cpm_pkg::CFG_POWER, pwr_v);
    // an index past the list must be ignored
    write_setting(spare_idx, 16'($urandom));
    cfg_write <= 1'b0;
  endtask

  // Short directed pass against the reset settings (device address 64).
  task automatic run_directed();
    // data and reads while deselected: ignored
    send_request(bus_msg(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'hAA));
    send_request(bus_msg(1'b0, 1'b0, 1'b0, 1'b1, 8'hFF, 8'h55));
    // read before any pointer write: starts at config MSB
    send_request(bus_msg(1'b1, 1'b0, 1'b0, 1'b0, HOME_RD, 8'h00));
    send_request(bus_msg(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    send_request(bus_msg(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    send_request(bus_msg(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    send_request(bus_msg(1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00));
    // pointer to calibration, write all ones, then read past the map
    send_request(bus_msg(1'b1, 1'b0, 1'b0, 1'b0, HOME_WR, 8'h00));
    send_request(bus_msg(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, i2cpm_pkg::REG_CALIBRATION));
    send_request(bus_msg(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'hFF));
    send_request(bus_msg(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'hFF));
    send_request(bus_msg(1'b1, 1'b0, 1'b0, 1'b0, HOME_RD, 8'h00));
    send_request(bus_msg(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    // stop and start in one request, then write config and read it back
    send_request(bus_msg(1'b1, 1'b1, 1'b1, 1'b0, HOME_WR, i2cpm_pkg::REG_CONFIG));
    send_request(bus_msg(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h12));
    send_request(bus_msg(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h34));
    send_request(bus_msg(1'b1, 1'b1, 1'b1, 1'b0, HOME_WR, i2cpm_pkg::REG_CONFIG));
    send_request(bus_msg(1'b1, 1'b0, 1'b0, 1'b1, HOME_RD, 8'h00));
    send_request(bus_msg(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    // config bit 15 restores the default
    send_request(bus_msg(1'b1, 1'b1, 1'b1, 1'b0, HOME_WR, i2cpm_pkg::REG_CONFIG));
    send_request(bus_msg(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h80));
    send_request(bus_msg(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00));
    // start for another address deselects silently
    send_request(bus_msg(1'b1, 1'b0, 1'b0, 1'b0, OTHER_WR, 8'h00));
    send_request(bus_msg(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    // every flag at once: three replies, then finish the word
    send_request(bus_msg(1'b1, 1'b1, 1'b1, 1'b1, HOME_WR, i2cpm_pkg::REG_CONFIG));
    send_request(bus_msg(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    send_request(bus_msg(1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00));
  endtask

  // Random traffic: mostly well-formed write and read transactions with random
  // content, the rest mixed-flag requests and noise.
  task automatic run_random(int n_items);
    int       sent, pick, count;
    bit [7:0] own_w, own_r, ra, rb;
    sent = 0;
    while (sent < n_items) begin
      own_w = {sb.dev_addr, 1'b0};
      own_r = {sb.dev_addr, 1'b1};
      pick  = $urandom_range(0, 9);
      count = $urandom_range(1, 7);
      if (pick <= 3) begin
        // pointer byte, then words; an odd count leaves a half word to drop
        ra = 8'($urandom);
        send_request(bus_msg(1'b1, 1'b0, 1'b0, 1'b0, own_w, ra));
        ra = 8'($urandom);
        rb = 8'($urandom);
        send_request(bus_msg(1'b0, 1'b0, 1'b1, 1'b0, ra, rb));
        repeat (count) begin
          ra = 8'($urandom);
          rb = 8'($urandom);
          send_request(bus_msg(1'b0, 1'b0, 1'b1, 1'b0, ra, rb));
        end
        send_request(bus_msg(1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00));
        sent += count + 3;
      end else if (pick <= 6) begin
        // optional pointer byte, repeated start for read, then reads
        send_request(bus_msg(1'b1, 1'b0, 1'b0, 1'b0, own_w, 8'h00));
        if ($urandom_range(0, 3) != 0) begin
          rb = 8'($urandom);
          send_request(bus_msg(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, rb));
          sent++;
        end
        send_request(bus_msg(1'b1, 1'b0, 1'b0, 1'b0, own_r, 8'h00));
        repeat (count) begin
          ra = 8'($urandom);
          rb = 8'($urandom);
          send_request(bus_msg(1'b0, 1'b0, 1'b0, 1'b1, ra, rb));
        end
        send_request(bus_msg(1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00));
        sent += count + 3;
      end else begin
        // mixed flags; on pick 7 all aimed at this device, else about half, the rest anywhere
        repeat (count) begin
          ra = 8'($urandom);
          rb = 8'($urandom);
          if (pick == 7 || $urandom_range(0, 1) == 1)
            ra[7:1] = sb.dev_addr;
          send_request(bus_msg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               ra, rb));
        end
        sent += count;
      end
    end
  endtask

  initial begin
    sb           = new();
    gaps_on      = 1'b1;
    rx_hold      = 0;
    cycle_count  = 0;
    seen_reply   = '0;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    is_start     = 1'b0;
    is_stop      = 1'b0;
    is_write     = 1'b0;
    is_read      = 1'b0;
    address_byte = '0;
    data_byte    = '0;
    out_ready    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    for (int phase = 0; phase < 5; phase++) begin
      settle();
      apply_settings(phase);
      // one phase with both sides flat out
      gaps_on = (phase != 2);
      run_random(32);
    end
    settle();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/i2cpm_pkg.sv
hw/rtl/i2cpm_msg_logic.sv
hw/rtl/i2cpm_reply_buf.sv
hw/rtl/i2c_power_monitor_registers.sv
hw/rtl/i2cpm_checker.sv
verif/tb_top.sv
